@@ rtl/core/kvl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvl_pkg: shared constants and functions for the keyframe vertex blender
// Holds the blend fraction format and the quarter-wave sine ROM that decodes
// a latitude/longitude byte into a Q1.14 sine value.
// ----------------------------------------------------------------------------
package kvl_pkg;

  localparam int FRAC_BITS  = 16;              // fraction bits of the blend factor
  localparam int FRAC_W     = FRAC_BITS + 1;   // register width, holds 1.0 exactly
  localparam int POS_SHIFT  = FRAC_BITS - 4;   // 1/64 -> 1/1024 leaves this many bits
  localparam int TRIG_W     = 16;              // Q1.14 with room for +1.0
  localparam int TRIG_FRAC  = 14;
  localparam int COORD_W    = 16;
  localparam int POS_W      = 20;
  localparam int NRM_W      = 16;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  typedef logic signed [TRIG_W-1:0] trig_t;

  // Quarter wave, round(16384 * sin(2*pi*k/256)) for k = 0..64.
  function automatic trig_t quarter_sine(input logic [6:0] idx);
    trig_t v;
    case (idx)
      7'd0:  v = 16'sd0;     7'd1:  v = 16'sd402;   7'd2:  v = 16'sd804;
      7'd3:  v = 16'sd1205;  7'd4:  v = 16'sd1606;  7'd5:  v = 16'sd2006;
      7'd6:  v = 16'sd2404;  7'd7:  v = 16'sd2801;  7'd8:  v = 16'sd3196;
      7'd9:  v = 16'sd3590;  7'd10: v = 16'sd3981;  7'd11: v = 16'sd4370;
      7'd12: v = 16'sd4756;  7'd13: v = 16'sd5139;  7'd14: v = 16'sd5520;
      7'd15: v = 16'sd5897;  7'd16: v = 16'sd6270;  7'd17: v = 16'sd6639;
      7'd18: v = 16'sd7005;  7'd19: v = 16'sd7366;  7'd20: v = 16'sd7723;
      7'd21: v = 16'sd8076;  7'd22: v = 16'sd8423;  7'd23: v = 16'sd8765;
      7'd24: v = 16'sd9102;  7'd25: v = 16'sd9434;  7'd26: v = 16'sd9760;
      7'd27: v = 16'sd10080; 7'd28: v = 16'sd10394; 7'd29: v = 16'sd10702;
      7'd30: v = 16'sd11003; 7'd31: v = 16'sd11297; 7'd32: v = 16'sd11585;
      7'd33: v = 16'sd11866; 7'd34: v = 16'sd12140; 7'd35: v = 16'sd12406;
      7'd36: v = 16'sd12665; 7'd37: v = 16'sd12916; 7'd38: v = 16'sd13160;
      7'd39: v = 16'sd13395; 7'd40: v = 16'sd13623; 7'd41: v = 16'sd13842;
      7'd42: v = 16'sd14053; 7'd43: v = 16'sd14256; 7'd44: v = 16'sd14449;
      7'd45: v = 16'sd14635; 7'd46: v = 16'sd14811; 7'd47: v = 16'sd14978;
      7'd48: v = 16'sd15137; 7'd49: v = 16'sd15286; 7'd50: v = 16'sd15426;
      7'd51: v = 16'sd15557; 7'd52: v = 16'sd15679; 7'd53: v = 16'sd15791;
      7'd54: v = 16'sd15893; 7'd55: v = 16'sd15986; 7'd56: v = 16'sd16069;
      7'd57: v = 16'sd16143; 7'd58: v = 16'sd16207; 7'd59: v = 16'sd16261;
      7'd60: v = 16'sd16305; 7'd61: v = 16'sd16340; 7'd62: v = 16'sd16364;
      7'd63: v = 16'sd16379; 7'd64: v = 16'sd16384;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Full-wave sine for an angle byte (2*pi/256 per step), folded onto the quarter wave.
  function automatic trig_t sine_byte(input logic [7:0] ang);
    logic [6:0] idx;
    trig_t      q;
    idx = ang[6] ? (7'd64 - {1'b0, ang[5:0]}) : {1'b0, ang[5:0]};
    q   = quarter_sine(idx);
    return ang[7] ? -q : q;
  endfunction

  // Cosine is the sine a quarter turn further on.
  function automatic trig_t cosine_byte(input logic [7:0] ang);
    return sine_byte(ang + 8'd64);
  endfunction

endpackage

@@ rtl/core/keyframe_vertex_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vertex_lerp: blend one vertex between two animation keyframes
// Interpolates the position with the configured fraction and rescales it to
// 1/1024 units; decodes both lat/long normals through a sine ROM and blends them.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake               | Payload
//  ---------+-----+-------------------------+----------------------------------
//  in_      | in  | in_tvalid / in_tready   | in_tdata  128 b, old and new vertex
//  out_     | out | out_tvalid / out_tready | out_tdata 112 b, position and normal
//  cfg_     | in  | cfg_valid / cfg_ready   | cfg_data   17 b, lerp_fraction
//
//  One beat is accepted per cycle while in_tready is high; each result passes
//  through the five register stages (ROM, products, rounding and normal
//  difference, normal blend product, final rounding).
//  A stall on out_tready holds the last stage; earlier stages keep filling
//  bubbles, so in_tready only drops once every stage holds a beat.
//  rst_n is synchronous, active low, clears the stage valids and the fraction.
module keyframe_vertex_lerp
  import kvl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  // old_x, old_y, old_z, old_packed_normal, new_x, new_y, new_z, new_packed_normal
  input  logic [127:0]  in_tdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, 4 zero bits
  output logic [111:0]  out_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic [FRAC_W-1:0] cfg_data,
  input  logic          cfg_valid,
  output logic          cfg_ready
);

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = FRAC_W + 1 + DIFF_W;     // signed fraction times difference
  localparam int NUM_W   = PROD_W + 1;
  localparam int TPROD_W = 2 * TRIG_W;
  localparam int NDIFF_W = NRM_W + 1;

  logic [FRAC_W-1:0] frac_r;
  logic signed [FRAC_W:0] frac_s;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  // Stage 1: coordinate differences and ROM outputs (index 0 old, 1 new frame)
  logic signed [COORD_W-1:0] pa1_r [3];
  logic signed [DIFF_W-1:0]  pd1_r [3];
  trig_t sin_lat1_r [2], cos_lat1_r [2], sin_lng1_r [2], cos_lng1_r [2];
  // Stage 2: products
  logic signed [COORD_W-1:0] pa2_r [3];
  logic signed [PROD_W-1:0]  pp2_r [3];
  logic signed [TPROD_W-1:0] nx2_r [2], ny2_r [2];
  trig_t nz2_r [2];
  // Stage 3: rounded position, decoded old normal and difference
  logic signed [POS_W-1:0]   pos3_r [3];
  logic signed [NRM_W-1:0]   nold3_r [3];
  logic signed [NDIFF_W-1:0] nd3_r [3];
  // Stage 4: normal blend product
  logic signed [POS_W-1:0]   pos4_r [3];
  logic signed [NRM_W-1:0]   nold4_r [3];
  logic signed [PROD_W-1:0]  np4_r [3];
  // Stage 5: result register
  logic signed [POS_W-1:0]   pos5_r [3];
  logic signed [NRM_W-1:0]   nrm5_r [3];

  logic signed [NRM_W-1:0]   ndec [2][3];

  assign frac_s    = signed'({1'b0, frac_r});
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frac_r <= (cfg_data > FRAC_ONE) ? FRAC_ONE : cfg_data;
    end
  end

  // A stage loads when it is empty or its contents move on.
  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        pa1_r[i] <= signed'(in_tdata[16*i +: COORD_W]);
        pd1_r[i] <= DIFF_W'(signed'(in_tdata[64 + 16*i +: COORD_W]))
                  - DIFF_W'(signed'(in_tdata[16*i +: COORD_W]));
      end
      for (int k = 0; k < 2; k++) begin
        sin_lat1_r[k] <= sine_byte(in_tdata[64*k + 56 +: 8]);
        cos_lat1_r[k] <= cosine_byte(in_tdata[64*k + 56 +: 8]);
        sin_lng1_r[k] <= sine_byte(in_tdata[64*k + 48 +: 8]);
        cos_lng1_r[k] <= cosine_byte(in_tdata[64*k + 48 +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        pa2_r[i] <= pa1_r[i];
        pp2_r[i] <= PROD_W'(frac_s) * PROD_W'(pd1_r[i]);
      end
      for (int k = 0; k < 2; k++) begin
        nx2_r[k] <= TPROD_W'(cos_lat1_r[k]) * TPROD_W'(sin_lng1_r[k]);
        ny2_r[k] <= TPROD_W'(sin_lat1_r[k]) * TPROD_W'(sin_lng1_r[k]);
        nz2_r[k] <= cos_lng1_r[k];
      end
    end
  end

  // Q1.14 product back to Q1.14, round half up.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ndec[k][0] = NRM_W'((nx2_r[k] + (TPROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC);
      ndec[k][1] = NRM_W'((ny2_r[k] + (TPROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC);
      ndec[k][2] = nz2_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        pos3_r[i]  <= POS_W'(((NUM_W'(pa2_r[i]) <<< FRAC_BITS) + NUM_W'(pp2_r[i])
                       + (NUM_W'(1) <<< (POS_SHIFT - 1))) >>> POS_SHIFT);
        nold3_r[i] <= ndec[0][i];
        nd3_r[i]   <= NDIFF_W'(ndec[1][i]) - NDIFF_W'(ndec[0][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        pos4_r[i]  <= pos3_r[i];
        nold4_r[i] <= nold3_r[i];
        np4_r[i]   <= PROD_W'(frac_s) * PROD_W'(nd3_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        pos5_r[i] <= pos4_r[i];
        nrm5_r[i] <= NRM_W'(((NUM_W'(nold4_r[i]) <<< FRAC_BITS) + NUM_W'(np4_r[i])
                      + (NUM_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      end
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {4'b0000,
                       nrm5_r[2], nrm5_r[1], nrm5_r[0],
                       pos5_r[2], pos5_r[1], pos5_r[0]};

  // An accepted beat always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted input beat did not enter stage one");

  // With no result pending the whole pipe can move, so input must be open.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage is empty");

  // A blocked stage keeps its beat.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en4 |=> v3_r && $stable(pos3_r[0]))
    else $error("stage three lost a stalled beat");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FRAC_ONE)
    else $error("blend fraction above one");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> nrm5_r[2] <= 16'sd16384 && nrm5_r[2] >= -16'sd16384
                && nrm5_r[0] <= 16'sd16384 && nrm5_r[0] >= -16'sd16384)
    else $error("blended normal out of unit range");

endmodule

@@ dv/keyframe_vertex_lerp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vertex_lerp_tb: self-checking bench for the keyframe vertex blender
// Streams old/new vertex pairs through the block under several blend
// fractions and idle patterns, predicts each blended position and normal in
// the bench, and checks every output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module keyframe_vertex_lerp_tb;
  import kvl_pkg::*;

  localparam int    CLK_HALF   = 4;
  localparam int    RESET_CYC  = 8;
  localparam int    SEG_ITEMS  = 200;
  localparam int    NUM_SEGS   = 8;
  localparam int    DRAIN_CYC  = 12;
  localparam int    HOLD_AT    = 1300;
  localparam int    HOLD_LEN   = 300;
  localparam int    CYCLE_LIMIT = 200000;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic [127:0]  in_tdata   = '0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [111:0]  out_tdata;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [FRAC_W-1:0] cfg_data = '0;
  logic          cfg_valid  = 1'b0;
  logic          cfg_ready;

  logic [127:0]  vertex_q [$];
  logic [111:0]  blend_q  [$];
  logic [FRAC_W-1:0] frac_model = '0;
  logic [FRAC_W-1:0] cfg_value  = '0;
  int            cfg_req = 0, cfg_sent = 0, cfg_done = 0;
  int            send_idle = 0, recv_idle = 0;
  int            beats_in = 0, beats_out = 0;
  int            errors = 0;
  int            cycles = 0;
  int            hold_cnt = 0;
  bit            hold_fired = 1'b0;

  // Quarter wave of the sine in Q1.14, one entry per 2*pi/256 step.
  int qsine [0:64] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370,
    4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
    9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866,
    12140, 12406, 12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256,
    14449, 14635, 14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791,
    15893, 15986, 16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
    16384
  };

  keyframe_vertex_lerp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #CLK_HALF clk = ~clk;

  // Round to nearest, ties toward plus infinity.
  function automatic longint round_sh(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sin_step(input logic [7:0] k);
    int r;
    r = int'(k[5:0]);
    case (k[7:6])
      2'd0:    return longint'(qsine[r]);
      2'd1:    return longint'(qsine[64 - r]);
      2'd2:    return -longint'(qsine[r]);
      default: return -longint'(qsine[64 - r]);
    endcase
  endfunction

  // One axis of a decoded lat/long normal, Q1.14.
  function automatic longint normal_axis(input logic [15:0] pn, input int axis);
    logic [7:0] lat, lng;
    lat = pn[15:8];
    lng = pn[7:0];
    case (axis)
      0:       return round_sh(sin_step(lat + 8'd64) * sin_step(lng), TRIG_FRAC);
      1:       return round_sh(sin_step(lat) * sin_step(lng), TRIG_FRAC);
      default: return sin_step(lng + 8'd64);
    endcase
  endfunction

  function automatic logic [111:0] blend_vertex(input logic [127:0] beat,
                                                input logic [FRAC_W-1:0] frac);
    logic [111:0] res;
    longint       f, one, a, b, p, na, nb;
    res = '0;
    one = longint'(1) <<< FRAC_BITS;
    f   = (frac > FRAC_ONE) ? one : longint'(frac);
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(beat[16*i +: 16]));
      b = longint'($signed(beat[64 + 16*i +: 16]));
      p = round_sh(a * one + f * (b - a), POS_SHIFT);
      res[20*i +: 20] = p[19:0];
      na = normal_axis(beat[63:48], i);
      nb = normal_axis(beat[127:112], i);
      p  = round_sh(na * one + f * (nb - na), FRAC_BITS);
      res[60 + 16*i +: 16] = p[15:0];
    end
    return res;
  endfunction

  function automatic logic [127:0] make_beat(
      input logic [15:0] ox, oy, oz, on, nx, ny, nz, nn);
    return {nn, nz, ny, nx, on, oz, oy, ox};
  endfunction

  // Extremes, zero and small values near zero show up often; half the draws are full-range.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [127:0] rand_beat();
    logic [15:0] f [8];
    for (int i = 0; i < 8; i++)
      f[i] = (i == 3 || i == 7) ? 16'($urandom) : rand_coord();
    // Some pairs share the same vertex, as in a static part of a mesh.
    if ($urandom_range(9) == 0)
      for (int i = 0; i < 4; i++)
        f[4 + i] = f[i];
    return make_beat(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
  endfunction

  task automatic report(input string what, input int idx,
                        input logic [31:0] got, input logic [31:0] want);
    $display("mismatch beat %0d %s[%0d]: got %h want %h", beats_out, what, idx, got, want);
    errors++;
  endtask

  // Input beat driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_tdata  <= vertex_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_fired && beats_in >= HOLD_AT) begin
      hold_cnt   <= HOLD_LEN;
      hold_fired <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Fraction register writes, requested by the sequence below.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid  <= 1'b0;
      frac_model <= cfg_data;
      cfg_done   <= cfg_done + 1;
    end else if (!cfg_valid && cfg_sent != cfg_req) begin
      cfg_valid <= 1'b1;
      cfg_data  <= cfg_value;
      cfg_sent  <= cfg_sent + 1;
    end
  end

  // Input capture comes before output checking so a same-cycle pair stays ordered.
  always @(posedge clk) begin
    logic [111:0] want;
    if (rst_n && in_tvalid && in_tready) begin
      blend_q.push_back(blend_vertex(in_tdata, frac_model));
      beats_in <= beats_in + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (blend_q.size() == 0) begin
        report("unexpected", 0, out_tdata[31:0], 32'h0);
      end else begin
        want = blend_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (out_tdata[20*i +: 20] !== want[20*i +: 20])
            report("pos", i, 32'(out_tdata[20*i +: 20]), 32'(want[20*i +: 20]));
          if (out_tdata[60 + 16*i +: 16] !== want[60 + 16*i +: 16])
            report("normal", i, 32'(out_tdata[60 + 16*i +: 16]),
                   32'(want[60 + 16*i +: 16]));
        end
        if (out_tdata[111:108] !== 4'h0)
          report("pad", 0, 32'(out_tdata[111:108]), 32'h0);
      end
      beats_out <= beats_out + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_fraction(input logic [FRAC_W-1:0] v);
    @(negedge clk);
    cfg_value = v;
    cfg_req++;
    while (cfg_done != cfg_req) @(negedge clk);
  endtask

  task automatic drain();
    while (vertex_q.size() != 0 || blend_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic push_directed();
    vertex_q.push_back(make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    vertex_q.push_back(make_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000,
                                 16'h8000, 16'h8000, 16'h8000, 16'hffff));
    vertex_q.push_back(make_beat(16'h8000, 16'h8000, 16'h8000, 16'h4040,
                                 16'h7fff, 16'h7fff, 16'h7fff, 16'hc0c0));
    vertex_q.push_back(make_beat(16'h7fff, 16'h8000, 16'h0000, 16'h8080,
                                 16'h8000, 16'h7fff, 16'hffff, 16'h40c0));
    vertex_q.push_back(make_beat(16'h0001, 16'hffff, 16'h0002, 16'h3f41,
                                 16'hffff, 16'h0001, 16'hfffe, 16'h01ff));
    vertex_q.push_back(make_beat(16'h1234, 16'hedcb, 16'h5555, 16'h2a7b,
                                 16'h1234, 16'hedcb, 16'h5555, 16'h2a7b));
    vertex_q.push_back(make_beat(16'h0000, 16'h0000, 16'h0000, 16'hbf7f,
                                 16'h0001, 16'h0003, 16'h0007, 16'h8140));
    vertex_q.push_back(make_beat(16'haaaa, 16'h5555, 16'hff00, 16'hc13f,
                                 16'h5555, 16'haaaa, 16'h00ff, 16'h3ec1));
  endtask

  initial begin
    logic [FRAC_W-1:0] seg_frac [NUM_SEGS];

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset fraction, a saturating one and one half.
    push_directed();
    drain();
    write_fraction(FRAC_MAX);
    push_directed();
    drain();
    write_fraction(FRAC_ONE >> 1);
    push_directed();
    drain();

    seg_frac[0] = FRAC_ONE;
    seg_frac[1] = 17'd1;
    seg_frac[2] = 17'($urandom_range(int'(FRAC_ONE)));
    seg_frac[3] = '0;
    seg_frac[4] = FRAC_ONE - 17'd1;
    seg_frac[5] = 17'($urandom_range(int'(FRAC_MAX), int'(FRAC_ONE) + 1));
    seg_frac[6] = 17'($urandom);
    seg_frac[7] = 17'($urandom_range(int'(FRAC_ONE)));

    for (int s = 0; s < NUM_SEGS; s++) begin
      // Sender-light first, then receiver-light, then no idling at all.
      if (s < 3) begin
        send_idle = 10;
        recv_idle = 64;
      end else if (s < 6) begin
        send_idle = 64;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_fraction(seg_frac[s]);
      for (int i = 0; i < SEG_ITEMS; i++)
        vertex_q.push_back(rand_beat());
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
